>>> hdl/sclp_pkg.sv
// Package for the serial command line parser.
// Holds byte codes, line scan state type and the blink prefix table.
// No dependencies.
package sclp_pkg;

	localparam int LINE_CAPACITY = 32;
	localparam int CNT_W = $clog2(LINE_CAPACITY);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_CAPACITY - 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] PREFIX_LEN = 3'd6;
	localparam logic [2:0] POS_MAX    = 3'd7;

	localparam logic [8:0] MAG_SAT   = 9'd256;
	localparam logic [8:0] MAG_LIMIT = 9'd25;
	localparam logic [8:0] DRIVE_MAX = 9'd255;

	localparam logic RES_DRIVE = 1'b0;
	localparam logic RES_BLINK = 1'b1;

	typedef enum logic [1:0] {
		NUM_START,
		NUM_SIGN,
		NUM_DIGITS,
		NUM_DONE
	} num_phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] stored_count;
		logic             leading_blank;
		logic [2:0]       prefix_position;
		logic             prefix_broken;
		logic [7:0]       tail_char;
		logic             tail_has_text;
		num_phase_t       number_phase;
		logic             negative_sign;
		logic [8:0]       magnitude;
		logic             cut_by_zero;
		logic             has_content;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		stored_count:    '0,
		leading_blank:   1'b1,
		prefix_position: 3'd0,
		prefix_broken:   1'b0,
		tail_char:       8'h00,
		tail_has_text:   1'b0,
		number_phase:    NUM_START,
		negative_sign:   1'b0,
		magnitude:       9'd0,
		cut_by_zero:     1'b0,
		has_content:     1'b0
	};

	typedef struct packed {
		logic               fire;
		logic               kind;
		logic signed [8:0]  drive;
		logic [7:0]         cmd;
	} line_result_t;

	function automatic logic [7:0] blink_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0: ch = 8'h42;
			3'd1: ch = 8'h4c;
			3'd2: ch = 8'h43;
			3'd3: ch = 8'h4d;
			3'd4: ch = 8'h44;
			3'd5: ch = 8'h3a;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

>>> hdl/sclp_in_if.sv
// Input channel of the serial command line parser: one received byte per item.
// No dependencies.
interface sclp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hdl/sclp_out_if.sv
// Result channel of the serial command line parser: drive value or blink command.
// No dependencies.
interface sclp_out_if;
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic signed [8:0] drive_value;
	logic [7:0]        command_char;

	modport source (output valid, output result_kind, output drive_value,
		output command_char, input ready);
	modport sink (input valid, input result_kind, input drive_value,
		input command_char, output ready);
endinterface

>>> hdl/sclp_scan.sv
// Line scanner: holds the per-line state and updates it once per accepted byte.
// Produces the result of a line when its newline arrives. Depends on sclp_pkg.
module sclp_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	output sclp_pkg::line_result_t result
);
	import sclp_pkg::*;

	line_state_t st_q;
	line_state_t st_nxt;

	logic       blank;
	logic       digit;
	logic       is_sign;
	logic [8:0] mag_x10;
	logic [8:0] mag_sum;
	logic [8:0] mag_nxt;
	logic [8:0] clamped;

	assign blank   = is_blank(rx_byte);
	assign digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_sign = (rx_byte == CH_MINUS) || (rx_byte == CH_PLUS);
	assign mag_x10 = (st_q.magnitude << 3) + (st_q.magnitude << 1);
	assign mag_sum = mag_x10 + {5'd0, rx_byte[3:0]};
	assign mag_nxt = (st_q.magnitude > MAG_LIMIT || mag_sum > MAG_SAT) ? MAG_SAT : mag_sum;

	always_comb begin
		st_nxt = st_q;
		if (rx_byte == CH_LF) begin
			st_nxt = LINE_CLEAR;
		end else if (rx_byte != CH_CR && st_q.stored_count < CNT_MAX) begin
			st_nxt.stored_count = st_q.stored_count + 1'b1;
			if (!st_q.cut_by_zero) begin
				if (rx_byte == CH_NUL) begin
					st_nxt.cut_by_zero = 1'b1;
				end else if (!(st_q.leading_blank && blank)) begin
					st_nxt.leading_blank = 1'b0;
					if (!blank)
						st_nxt.has_content = 1'b1;
					if (st_q.prefix_position < PREFIX_LEN) begin
						if (rx_byte != blink_char(st_q.prefix_position))
							st_nxt.prefix_broken = 1'b1;
					end else begin
						if (st_q.prefix_position == PREFIX_LEN)
							st_nxt.tail_char = rx_byte;
						if (!blank)
							st_nxt.tail_has_text = 1'b1;
					end
					if (st_q.prefix_position < POS_MAX)
						st_nxt.prefix_position = st_q.prefix_position + 3'd1;
					unique case (st_q.number_phase)
						NUM_START: begin
							if (is_sign) begin
								st_nxt.negative_sign = (rx_byte == CH_MINUS);
								st_nxt.number_phase  = NUM_SIGN;
							end else if (digit) begin
								st_nxt.magnitude    = mag_nxt;
								st_nxt.number_phase = NUM_DIGITS;
							end else begin
								st_nxt.number_phase = NUM_DONE;
							end
						end
						NUM_SIGN, NUM_DIGITS: begin
							if (digit) begin
								st_nxt.magnitude    = mag_nxt;
								st_nxt.number_phase = NUM_DIGITS;
							end else begin
								st_nxt.number_phase = NUM_DONE;
							end
						end
						NUM_DONE: begin
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LINE_CLEAR;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	assign clamped = (st_q.magnitude > DRIVE_MAX) ? DRIVE_MAX : st_q.magnitude;

	always_comb begin
		result.fire  = accept && (rx_byte == CH_LF) && st_q.has_content;
		result.kind  = (!st_q.prefix_broken && st_q.tail_has_text) ? RES_BLINK : RES_DRIVE;
		result.drive = 9'sd0;
		result.cmd   = 8'h00;
		if (result.kind == RES_BLINK)
			result.cmd = st_q.tail_char;
		else
			result.drive = st_q.negative_sign ? -$signed(clamped) : $signed(clamped);
	end

	a_clear_on_newline: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rx_byte == CH_LF |=> st_q.stored_count == '0 && st_q.leading_blank
			&& !st_q.has_content)
		else $error("line state not cleared after newline");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.stored_count <= CNT_MAX)
		else $error("stored count beyond line capacity");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.magnitude <= MAG_SAT)
		else $error("magnitude beyond saturation");

endmodule

>>> hdl/serial_command_line_parser.sv
// Serial command line parser, one received byte per item, one item per cycle.
// Each byte is folded into the line state in the cycle it is accepted, and a
// newline that closes a non-empty line loads one result into the output
// register, ready on the next cycle. A byte is taken every cycle while the
// output register is empty or being drained; the output register alone sets
// when input is held off. There is no clearing pass after reset.
// Depends on sclp_pkg, sclp_in_if, sclp_out_if and sclp_scan.
module serial_command_line_parser (
	input  logic      clk,
	input  logic      arst_n,
	sclp_in_if.sink   rx,
	sclp_out_if.source res
);
	import sclp_pkg::*;

	logic         accept;
	line_result_t result;

	logic              valid_q;
	logic              kind_q;
	logic signed [8:0] drive_q;
	logic [7:0]        cmd_q;

	assign rx.ready = !valid_q || res.ready;
	assign accept   = rx.valid && rx.ready;

	sclp_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.fire) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.fire) begin
			kind_q  <= result.kind;
			drive_q <= result.drive;
			cmd_q   <= result.cmd;
		end
	end

	assign res.valid        = valid_q;
	assign res.result_kind  = kind_q;
	assign res.drive_value  = drive_q;
	assign res.command_char = cmd_q;

	a_blink_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == RES_BLINK |-> drive_q == 9'sd0)
		else $error("blink result carries a drive value");

	a_drive_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == RES_DRIVE |-> cmd_q == 8'h00)
		else $error("drive result carries a command character");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> drive_q != -9'sd256)
		else $error("drive value outside clamp range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res.ready |-> !result.fire)
		else $error("result lost while output stalled");

endmodule

>>> bench/tb_serial_command_line_parser.sv
// Testbench for serial_command_line_parser: drives received bytes, predicts each
// drive value or blink command from its own line scanner and checks every result.
// Depends on sclp_pkg, sclp_in_if, sclp_out_if and the parser RTL.
module tb_serial_command_line_parser;
	import sclp_pkg::*;

	localparam logic [7:0] CH_VT = 8'h0b;
	localparam logic [7:0] CH_FF = 8'h0c;
	localparam logic [47:0] BLINK_TAG = "BLCMD:";
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic              kind;
		logic signed [8:0] drive;
		logic [7:0]        cmd;
	} outcome_t;

	typedef enum {RCV_OPEN, RCV_COIN, RCV_COMB, RCV_SPARSE} rcv_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sclp_in_if rx_if();
	sclp_out_if res_if();

	serial_command_line_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.res(res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// line scanner state
	int         ln_kept;
	bit         ln_lead;
	int         ln_pos;
	bit         ln_pfx_bad;
	logic [7:0] ln_tail;
	bit         ln_tail_text;
	num_phase_t ln_phase;
	bit         ln_neg;
	int         ln_mag;
	bit         ln_cut;
	bit         ln_content;

	outcome_t line_results_q[$];
	outcome_t want_res;

	int errors = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int blinks_seen = 0;

	bit gaps_on = 1'b1;
	int burst_left = 0;

	int hold_req = 0;
	int hold_left = 0;
	rcv_style_t rcv_style = RCV_OPEN;
	int rcv_style_left = 0;
	int rcv_tick = 0;

	function automatic void clear_line_scan();
		ln_kept = 0;
		ln_lead = 1'b1;
		ln_pos = 0;
		ln_pfx_bad = 1'b0;
		ln_tail = 8'h00;
		ln_tail_text = 1'b0;
		ln_phase = NUM_START;
		ln_neg = 1'b0;
		ln_mag = 0;
		ln_cut = 1'b0;
		ln_content = 1'b0;
	endfunction

	function automatic void scan_line_char(input logic [7:0] c);
		bit blank;
		bit digit;
		int nxt;
		blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (ln_lead && blank)
			return;
		ln_lead = 1'b0;
		if (!blank)
			ln_content = 1'b1;
		if (ln_pos < 6) begin
			if (c != BLINK_TAG[47 - 8 * ln_pos -: 8])
				ln_pfx_bad = 1'b1;
		end else begin
			if (ln_pos == 6)
				ln_tail = c;
			if (!blank)
				ln_tail_text = 1'b1;
		end
		if (ln_pos < 7)
			ln_pos++;
		if (ln_phase == NUM_START && (c == CH_MINUS || c == CH_PLUS)) begin
			ln_neg = (c == CH_MINUS);
			ln_phase = NUM_SIGN;
			return;
		end
		if (ln_phase != NUM_DONE) begin
			if (digit) begin
				nxt = (ln_mag > 25) ? 256 : ln_mag * 10 + int'(c - CH_ZERO);
				ln_mag = (nxt > 256) ? 256 : nxt;
				ln_phase = NUM_DIGITS;
			end else begin
				ln_phase = NUM_DONE;
			end
		end
	endfunction

	function automatic bit fold_line_byte(input logic [7:0] c, output outcome_t o);
		bit got;
		int v;
		got = 1'b0;
		o.kind = RES_DRIVE;
		o.drive = 9'sd0;
		o.cmd = 8'h00;
		if (c == CH_CR)
			return 1'b0;
		if (c == CH_LF) begin
			if (ln_content) begin
				got = 1'b1;
				if (!ln_pfx_bad && ln_tail_text) begin
					o.kind = RES_BLINK;
					o.cmd = ln_tail;
				end else begin
					v = (ln_mag > 255) ? 255 : ln_mag;
					if (ln_neg)
						v = -v;
					o.drive = v[8:0];
				end
			end
			clear_line_scan();
			return got;
		end
		if (ln_kept + 1 < LINE_CAPACITY) begin
			ln_kept++;
			if (!ln_cut) begin
				if (c == CH_NUL)
					ln_cut = 1'b1;
				else
					scan_line_char(c);
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return CH_TAB;
			1: return CH_VT;
			2: return CH_FF;
			3: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		outcome_t o;
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		if (fold_line_byte(b, o))
			line_results_q.push_back(o);
		bytes_sent++;
		if (gaps_on) begin
			if (burst_left == 0) begin
				rx_if.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic settle_results();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (line_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed_lines();
		send_text("0"); send_byte(CH_LF);
		send_text("255"); send_byte(CH_LF);
		send_text("-255"); send_byte(CH_LF);
		send_text("+17"); send_byte(CH_LF);
		send_text("-0"); send_byte(CH_LF);
		send_text("256"); send_byte(CH_LF);
		send_text("-987654321"); send_byte(CH_LF);
		send_text("BLCMD:A"); send_byte(CH_LF);
		send_byte(CH_TAB); send_text(" BLCMD:z tail "); send_byte(CH_FF); send_byte(CH_LF);
		send_text("BLCMD:  "); send_byte(CH_VT); send_byte(CH_LF);
		send_text("BLCMD:"); send_byte(CH_LF);
		send_text("BLCmD:x"); send_byte(CH_LF);
		send_byte(CH_LF);
		send_byte(CH_TAB); send_byte(CH_VT); send_byte(CH_FF); send_text(" "); send_byte(CH_LF);
		send_byte(CH_VT); send_text(" 42 "); send_byte(CH_TAB); send_byte(CH_LF);
		send_text("-"); send_byte(CH_LF);
		send_text("+ 5"); send_byte(CH_LF);
		send_text("12abc34"); send_byte(CH_LF);
		send_text("4"); send_byte(CH_NUL); send_text("99"); send_byte(CH_LF);
		send_byte(CH_NUL); send_text("5"); send_byte(CH_LF);
		send_text("                              77"); send_byte(CH_LF);
		send_text("1"); send_byte(CH_CR); send_text("2"); send_byte(CH_LF);
		send_byte(CH_CR); send_byte(CH_LF);
		send_text("BLCMD:"); send_byte(8'hff); send_byte(CH_LF);
		send_text("BLCMD:"); send_byte(CH_NUL); send_text("q"); send_byte(CH_LF);
		send_byte(8'h80); send_byte(8'h7f); send_byte(CH_LF);
	endtask

	task automatic test_random_lines();
		logic [7:0] line_q[$];
		int start;
		int pick;
		int n;
		logic [7:0] c;
		start = bytes_sent;
		while (bytes_sent - start < 790) begin
			line_q.delete();
			gaps_on = ($urandom_range(0, 4) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				repeat ($urandom_range(0, 3)) line_q.push_back(pick_blank());
				case ($urandom_range(0, 2))
					0: line_q.push_back(CH_MINUS);
					1: line_q.push_back(CH_PLUS);
					default: ;
				endcase
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
				repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(33, 126)));
				repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
				if ($urandom_range(0, 9) == 0)
					line_q.insert($urandom_range(0, line_q.size()), CH_CR);
			end else if (pick < 70) begin
				repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
				for (int i = 0; i < 6; i++)
					line_q.push_back(BLINK_TAG[47 - 8 * i -: 8]);
				if ($urandom_range(0, 6) == 0)
					line_q[line_q.size() - 1 - $urandom_range(0, 5)] = 8'($urandom_range(0, 255));
				c = 8'($urandom_range(0, 255));
				line_q.push_back((c == CH_LF) ? 8'h78 : c);
				repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(33, 126)));
				repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
			end else if (pick < 85) begin
				repeat ($urandom_range(0, 40)) line_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(25, 45))
					line_q.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE
						: CH_ZERO + 8'($urandom_range(0, 9)));
			end
			foreach (line_q[i])
				send_byte(line_q[i]);
			send_byte(CH_LF);
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_output_hold();
		gaps_on = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (40) begin
			send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
			send_byte(CH_LF);
		end
		while (hold_req != 0 || hold_left != 0)
			@(posedge clk);
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		rcv_tick++;
		if (rcv_style_left == 0) begin
			rcv_style = rcv_style_t'($urandom_range(0, 3));
			rcv_style_left = $urandom_range(40, 200);
		end else begin
			rcv_style_left--;
		end
		if (hold_left == 0 && hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			case (rcv_style)
				RCV_OPEN: res_if.ready <= 1'b1;
				RCV_COIN: res_if.ready <= 1'($urandom_range(0, 1));
				RCV_COMB: res_if.ready <= (rcv_tick % 11) >= 4;
				default: res_if.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (line_results_q.size() == 0) begin
				$display("%0t unexpected result: expected none, got kind %0d drive %0d cmd %02h",
					$time, res_if.result_kind, res_if.drive_value, res_if.command_char);
				errors++;
			end else begin
				want_res = line_results_q.pop_front();
				results_seen++;
				if (want_res.kind == RES_BLINK)
					blinks_seen++;
				if (res_if.result_kind !== want_res.kind) begin
					$display("%0t result_kind mismatch: expected %0d, got %0d",
						$time, want_res.kind, res_if.result_kind);
					errors++;
				end
				if (res_if.drive_value !== want_res.drive) begin
					$display("%0t drive_value mismatch: expected %0d, got %0d",
						$time, want_res.drive, res_if.drive_value);
					errors++;
				end
				if (res_if.command_char !== want_res.cmd) begin
					$display("%0t command_char mismatch: expected %02h, got %02h",
						$time, want_res.cmd, res_if.command_char);
					errors++;
				end
			end
		end
	end

	initial begin
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		res_if.ready = 1'b0;
		clear_line_scan();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lines();
		settle_results();
		test_output_hold();
		settle_results();
		test_random_lines();
		settle_results();
		if (line_results_q.size() != 0) begin
			$display("%0t missing results: expected %0d more, got 0",
				$time, line_results_q.size());
			errors++;
		end
		$display("Fed %0d bytes over directed, output-hold and random lines.", bytes_sent);
		$display("Checked %0d results: %0d drive values, %0d blink commands.",
			results_seen, results_seen - blinks_seen, blinks_seen);
		if (errors == 0)
			$display("serial_command_line_parser verification clean");
		else
			$display("serial_command_line_parser verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("serial_command_line_parser verification failed");
		$finish;
	end

endmodule
